/* design/dosr_pkg.sv */
// Shared constants and types for the dot-product / absolute-sum reducer.
package dosr_pkg;

  localparam logic MODE_DOT = 1'b0;
  localparam logic MODE_ABS = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* design/dosr_front.sv */
// Front end: accepts element pairs and forms the term to be accumulated.
module dosr_front import dosr_pkg::*; #(
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         mode,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ELEMENT_WIDTH-1:0]     in_x_value,
  input  logic [ELEMENT_WIDTH-1:0]     in_y_value,
  input  logic                         in_last,
  input  q_status_t                    q_status,
  output logic                         push,
  output logic [2*ELEMENT_WIDTH:0]     push_data
);

  localparam int TW = 2 * ELEMENT_WIDTH;

  logic signed [TW-1:0] prod;
  logic signed [TW-1:0] x_ext;
  logic signed [TW-1:0] abs_x;
  logic        [TW-1:0] term;
  logic                 last_seen_r;
  logic                 last_seen_nxt;

  assign prod  = $signed(in_x_value) * $signed(in_y_value);
  assign x_ext = {{(TW-ELEMENT_WIDTH){in_x_value[ELEMENT_WIDTH-1]}}, in_x_value};
  assign abs_x = in_x_value[ELEMENT_WIDTH-1] ? -x_ext : x_ext;

  always_comb begin
    case (mode)
      MODE_ABS: term = abs_x;
      MODE_DOT: term = prod;
      default:  term = prod;
    endcase
  end

  assign in_stall  = q_status.full;
  assign push      = in_valid && !q_status.full;
  assign push_data = {in_last, term};

  // Tracks whether the most recent transfer closed a vector.
  assign last_seen_nxt = push ? in_last : last_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r <= 1'b1;
    end else begin
      last_seen_r <= last_seen_nxt;
    end
  end

  // A transfer is never taken while the queue reports full.
  assert property (@(posedge clk) disable iff (!rst_n) q_status.full |-> !push)
    else $error("Transfer accepted into a full queue.");
  // After a transfer the tracked flag matches the last bit of that transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    push |=> last_seen_r == $past(in_last))
    else $error("Vector boundary tracking lost.");

endmodule

/* design/dosr_queue.sv */
// Small register queue that decouples term generation from accumulation.
module dosr_queue import dosr_pkg::*; #(
  parameter int DATA_WIDTH = 33
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] head_data,
  output q_status_t             status
);

  logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r;
  logic [QPTR_W-1:0]     wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r;
  logic [QPTR_W-1:0]     rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r;
  logic [QCNT_W-1:0]     count_nxt;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign head_data    = mem[rd_ptr_r];

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("Queue occupancy exceeds its depth.");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && status.empty))
    else $error("Queue popped while empty.");

endmodule

/* design/dosr_back.sv */
// Back end: saturating accumulator and result output register.
module dosr_back import dosr_pkg::*; #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int SUM_WIDTH     = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2*ELEMENT_WIDTH:0] head_data,
  input  q_status_t              q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SUM_WIDTH-1:0]   out_total,
  output logic                   out_saturated
);

  localparam int TW = 2 * ELEMENT_WIDTH;
  localparam int AW = ((SUM_WIDTH > TW) ? SUM_WIDTH : TW) + 1;

  logic                 q_last;
  logic [TW-1:0]        q_term;
  logic [AW-1:0]        sum_wide;
  logic                 ovf;
  logic [SUM_WIDTH-1:0] sum_sat;
  logic [SUM_WIDTH-1:0] acc_r;
  logic [SUM_WIDTH-1:0] acc_nxt;
  logic                 clip_r;
  logic                 clip_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [SUM_WIDTH-1:0] out_total_r;
  logic                 out_sat_r;

  assign q_last = head_data[TW];
  assign q_term = head_data[TW-1:0];

  assign sum_wide = {{(AW-SUM_WIDTH){acc_r[SUM_WIDTH-1]}}, acc_r}
                  + {{(AW-TW){q_term[TW-1]}}, q_term};

  assign ovf = !((&sum_wide[AW-1:SUM_WIDTH-1]) || !(|sum_wide[AW-1:SUM_WIDTH-1]));

  always_comb begin
    if (!ovf) begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end else if (sum_wide[AW-1]) begin
      sum_sat = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end
  end

  assign pop = !q_status.empty && (!q_last || !out_valid_r || !out_stall);

  always_comb begin
    acc_nxt       = acc_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      if (q_last) begin
        acc_nxt       = '0;
        clip_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt  = sum_sat;
        clip_nxt = clip_r || ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_last) begin
      out_total_r <= sum_sat;
      out_sat_r   <= clip_r || ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_total     = out_total_r;
  assign out_saturated = out_sat_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_last) |=> (out_valid_r && acc_r == '0 && !clip_r))
    else $error("Closing a vector did not present a result and clear the sum.");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && q_last) |-> !pop)
    else $error("A held result would be overwritten.");

endmodule

/* design/dot_or_abs_sum_reducer_core.sv */
// Top level of the streaming dot-product / absolute-sum reducer.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid / in_stall    | in_x_value, in_y_value, in_last
//   out     | output    | out_valid / out_stall  | out_total, out_saturated
//   cfg     | input     | cfg_wr_en              | cfg_wr_data (reduce mode)
//
// One element pair is taken per cycle while the queue is not full; in_stall mirrors full.
// A transfer on the input reaches the accumulator through the queue, and the result
// of a vector appears on the output the cycle after its last pair is accumulated.
// Reset clears the mode to dot product, the running sum, the clip flag and the queue.
// A stalled output only holds back the next last pair; pairs ahead of it keep accumulating.
module dot_or_abs_sum_reducer_core import dosr_pkg::*; #(
  parameter int ELEMENT_WIDTH = 16,
  parameter int SUM_WIDTH     = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ELEMENT_WIDTH-1:0] in_x_value,
  input  logic [ELEMENT_WIDTH-1:0] in_y_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SUM_WIDTH-1:0]     out_total,
  output logic                     out_saturated
);

  localparam int DW = 2 * ELEMENT_WIDTH + 1;

  logic          mode_r;
  logic          mode_nxt;
  logic          push;
  logic [DW-1:0] push_data;
  logic          pop;
  logic [DW-1:0] head_data;
  q_status_t     q_status;

  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DOT;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  dosr_front #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_x_value (in_x_value),
    .in_y_value (in_y_value),
    .in_last    (in_last),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  dosr_queue #(
    .DATA_WIDTH (DW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_status)
  );

  dosr_back #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .SUM_WIDTH     (SUM_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_data     (head_data),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_total     (out_total),
    .out_saturated (out_saturated)
  );

endmodule
